### rtl/rrts_pkg.sv
package rrts_pkg;

	localparam int ID_W   = 8;
	localparam int TIME_W = 16;
	localparam int STAT_W = 3;

	// result status codes
	localparam logic [STAT_W-1:0] ST_ADDED    = 3'd0;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
	localparam logic [STAT_W-1:0] ST_ZERO     = 3'd2;
	localparam logic [STAT_W-1:0] ST_RAN      = 3'd3;
	localparam logic [STAT_W-1:0] ST_IDLE     = 3'd4;

	localparam logic ACT_ADD  = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] remaining;
	} job_t;

endpackage

### rtl/round_robin_tick_scheduler_core.sv
// Round-robin job scheduler with a programmable time slice.
//
// Command channel: an item (action, cpu_time) is taken at a rising edge where
// start is high and busy is low. action 0 adds a job of cpu_time units at the
// queue tail under the next id; action 1 runs the head job for one unit.
// Result channel: done is high for exactly one cycle with status, proc_id and
// finished; the receiver must take it in that cycle, there is no back pressure.
// Timing: an add returns its result in the cycle after the transfer and the
// block can take the next item in that same cycle, so adds run one per cycle.
// A tick reads the head entry of the job memory (registered read) as it moves
// to the run state, then updates and writes it back and registers its result;
// busy is high in the run state, so the block takes no new item until the
// tick's result appears. The memory read followed by write-back causes this.
// Configuration: cfg_we with cfg_wdata writes time_slice (0 acts as 1). The user
// must write it only while no item is in flight; the block does not enforce this.
// Reset: arst_n clears the queue pointers, job count, slice counter and id
// counter and sets time_slice to 1; the job memory itself is not cleared,
// only entries inside the live queue are ever used.
module round_robin_tick_scheduler_core #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          action,
	input  logic [rrts_pkg::TIME_W-1:0]   cpu_time,
	input  logic                          cfg_we,
	input  logic [7:0]                    cfg_wdata,
	output logic                          done,
	output logic [rrts_pkg::STAT_W-1:0]   status,
	output logic [rrts_pkg::ID_W-1:0]     proc_id,
	output logic                          finished
);
	import rrts_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	typedef enum logic {S_IDLE, S_RUN} state_t;

	state_t            state_q;
	logic [PTR_W-1:0]  head_q, tail_q;
	logic [CNT_W-1:0]  count_q;
	logic [7:0]        slice_q;
	logic [ID_W-1:0]   next_id_q;
	logic [7:0]        time_slice_q;
	logic              done_q;
	logic [STAT_W-1:0] status_q;
	logic [ID_W-1:0]   proc_id_q;
	logic              finished_q;

	job_t              mem_q [QUEUE_DEPTH];
	job_t              rd_q;

	logic              accept;
	logic              mem_we;
	logic [PTR_W-1:0]  mem_waddr;
	job_t              mem_wdata;
	logic [TIME_W-1:0] rem_dec;
	logic [7:0]        slice_inc;
	logic [7:0]        limit;
	logic              tick_fin;
	logic              tick_rot;
	logic              q_empty;
	logic              q_full;

	function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
		adv = (p == LAST_PTR) ? '0 : p + 1'b1;
	endfunction

	assign busy     = (state_q == S_RUN);
	assign accept   = start && !busy;
	assign done     = done_q;
	assign status   = status_q;
	assign proc_id  = proc_id_q;
	assign finished = finished_q;

	assign q_empty   = (count_q == '0);
	assign q_full    = (count_q == FULL_CNT);
	assign rem_dec   = rd_q.remaining - 1'b1;
	assign slice_inc = slice_q + 8'd1;
	assign limit     = (time_slice_q == 8'd0) ? 8'd1 : time_slice_q;
	assign tick_fin  = (rem_dec == '0);
	assign tick_rot  = !tick_fin && (slice_inc >= limit);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = tail_q;
		mem_wdata = '{id: rd_q.id, remaining: rem_dec};
		if (accept && action == ACT_ADD) begin
			mem_we    = !q_full && (cpu_time != '0);
			mem_wdata = '{id: next_id_q, remaining: cpu_time};
		end else if (state_q == S_RUN && !q_empty && !tick_fin) begin
			// rotation moves the job to the tail, otherwise write back in place
			mem_we    = 1'b1;
			mem_waddr = tick_rot ? tail_q : head_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem_q[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			slice_q      <= '0;
			next_id_q    <= '0;
			time_slice_q <= 8'd1;
			done_q       <= 1'b0;
			status_q     <= ST_IDLE;
			proc_id_q    <= '0;
			finished_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				time_slice_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (action == ACT_ADD) begin
							done_q     <= 1'b1;
							finished_q <= 1'b0;
							if (q_full) begin
								status_q  <= ST_FULL;
								proc_id_q <= '0;
							end else if (cpu_time == '0) begin
								status_q  <= ST_ZERO;
								proc_id_q <= next_id_q;
								next_id_q <= next_id_q + 1'b1;
							end else begin
								status_q  <= ST_ADDED;
								proc_id_q <= next_id_q;
								next_id_q <= next_id_q + 1'b1;
								tail_q    <= adv(tail_q);
								count_q   <= count_q + 1'b1;
							end
						end else begin
							state_q <= S_RUN;
						end
					end
				end
				S_RUN: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					if (q_empty) begin
						status_q   <= ST_IDLE;
						proc_id_q  <= '0;
						finished_q <= 1'b0;
						next_id_q  <= '0;
					end else begin
						status_q   <= ST_RAN;
						proc_id_q  <= rd_q.id;
						finished_q <= tick_fin;
						if (tick_fin) begin
							head_q  <= adv(head_q);
							count_q <= count_q - 1'b1;
							slice_q <= '0;
							if (count_q == CNT_W'(1)) begin
								next_id_q <= '0;
							end
						end else if (tick_rot) begin
							head_q  <= adv(head_q);
							tail_q  <= adv(tail_q);
							slice_q <= '0;
						end else begin
							slice_q <= slice_inc;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("job count above queue depth");

	a_ptrs_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == tail_q))
		else $error("pointers differ on empty queue");

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q == S_RUN) || $past(accept && action == ACT_ADD)))
		else $error("result without an item");

	a_fin_ran: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && finished_q) |-> (status_q == ST_RAN))
		else $error("finished flag on a non-run result");

	a_run_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |=> (state_q == S_IDLE && done_q))
		else $error("tick did not complete in one cycle");

endmodule
